>>> rtl/encoder_period_tachometer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the encoder period tachometer
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ENCODER_PERIOD_TACHOMETER_ASSERT_SVH
`define ENCODER_PERIOD_TACHOMETER_ASSERT_SVH

// Plain property, checked at every edge out of reset.
`define ETP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define ETP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ETP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/etp_pkg.sv
// ----------------------------------------------------------------------------
// etp_pkg
// Widths, reset values, register indexes and shared types of the tachometer.
// ----------------------------------------------------------------------------
package etp_pkg;

  localparam int NUM_W             = 40;
  localparam int STALL_W           = 8;
  localparam int STAMP_W           = 32;
  localparam int SPEED_W           = 21;
  localparam int EDGES_PER_MEASURE = 16;
  localparam int PHASE_W           = $clog2(EDGES_PER_MEASURE);
  localparam int DIV_CNT_W         = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W         = 1;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL    = 1'b1;

  localparam logic [NUM_W-1:0]   NUM_RESET   = 40'd109282150;
  localparam logic [STALL_W-1:0] STALL_RESET = 8'd3;
  localparam logic [STALL_W-1:0] IDLE_MAX    = {STALL_W{1'b1}};

  // magnitude limits, forward and backward
  localparam logic [NUM_W-1:0] SPEED_POS_MAX = NUM_W'((64'd1 << (SPEED_W - 1)) - 64'd1);
  localparam logic [NUM_W-1:0] SPEED_NEG_MAX = NUM_W'(64'd1 << (SPEED_W - 1));

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/encoder_period_tachometer.sv
// ----------------------------------------------------------------------------
// encoder_period_tachometer
// Wheel speed from quadrature encoder edge timestamps, reported once per tick.
// ----------------------------------------------------------------------------
// Each input word is either an encoder edge (kind 0) or a control tick
// (kind 1). Edges return nothing: they clear the stall count, every
// sixteenth edge latches the time since the previous sixteenth edge as
// the period, and a rising A edge sets direction from the B level.
// Each tick returns exactly one output word: speed in rpm*256, signed by
// direction and saturated to 21 bits, or zero when the wheel has stalled or
// no period has been measured yet. A tick that reads zero passes from
// ST_IDLE through ST_OUT to the output register; any other tick first
// waits in ST_DIV on a bit-serial divider (one quotient bit per cycle over
// the 40-bit numerator), during which in_ready_o is low. Edges are still accepted while
// a finished word waits on out_ready_i. Config writes are always accepted
// and must only be issued while the block is idle.
module encoder_period_tachometer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [etp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [etp_pkg::NUM_W-1:0]     cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic                          from_channel_a_i,
  input  logic                          level_a_i,
  input  logic                          level_b_i,
  input  logic [etp_pkg::STAMP_W-1:0]   time_us_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [etp_pkg::SPEED_W-1:0] speed_q8_o,
  output logic                          moving_backward_o
);

`include "encoder_period_tachometer_assert.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  // config registers
  logic [etp_pkg::NUM_W-1:0]   rate_num_q;
  logic [etp_pkg::STALL_W-1:0] stall_ticks_q;

  // measurement state
  logic [etp_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [etp_pkg::STALL_W-1:0] idle_ticks_q, idle_ticks_d;
  logic [etp_pkg::STAMP_W-1:0] last_stamp_q, last_stamp_d;
  logic [etp_pkg::STAMP_W-1:0] period_q, period_d;
  logic                        backward_q, backward_d;

  // sequencer and output word
  logic [1:0]                  state_q, state_d;
  logic [etp_pkg::SPEED_W-1:0] res_q, res_d;
  logic                        out_valid_q, out_valid_d;
  logic [etp_pkg::SPEED_W-1:0] speed_q, speed_d;
  logic                        out_back_q, out_back_d;

  logic                        in_acc;
  logic                        div_start;
  etp_pkg::div_stat_t          div_stat;
  logic [etp_pkg::NUM_W-1:0]   quotient;
  logic [etp_pkg::NUM_W-1:0]   limit;
  logic [etp_pkg::SPEED_W-1:0] mag;
  logic [etp_pkg::STALL_W-1:0] idle_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  assign idle_inc = (idle_ticks_q == etp_pkg::IDLE_MAX) ? idle_ticks_q
                                                        : idle_ticks_q + 1'b1;

  // saturate the quotient; direction cannot change while a tick is in flight
  assign limit = backward_q ? etp_pkg::SPEED_NEG_MAX : etp_pkg::SPEED_POS_MAX;
  assign mag   = (quotient > limit) ? limit[etp_pkg::SPEED_W-1:0]
                                    : quotient[etp_pkg::SPEED_W-1:0];

  etp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rate_num_q),
    .divisor_i  (period_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  always_comb begin
    phase_d      = phase_q;
    idle_ticks_d = idle_ticks_q;
    last_stamp_d = last_stamp_q;
    period_d     = period_q;
    backward_d   = backward_q;
    state_d      = state_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    speed_d      = speed_q;
    out_back_d   = out_back_q;
    div_start    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && !kind_i) begin
          // encoder edge
          idle_ticks_d = '0;
          if (phase_q == etp_pkg::PHASE_W'(etp_pkg::EDGES_PER_MEASURE - 1)) begin
            phase_d      = '0;
            period_d     = time_us_i - last_stamp_q;
            last_stamp_d = time_us_i;
          end else begin
            phase_d = phase_q + 1'b1;
          end
          if (from_channel_a_i && level_a_i) begin
            backward_d = !level_b_i;
          end
        end else if (in_acc) begin
          // control tick
          idle_ticks_d = idle_inc;
          if (idle_inc >= stall_ticks_q || period_q == '0) begin
            res_d   = '0;
            state_d = ST_OUT;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_d   = backward_q ? (~mag + 1'b1) : mag;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          speed_d     = res_q;
          out_back_d  = backward_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_num_q    <= etp_pkg::NUM_RESET;
      stall_ticks_q <= etp_pkg::STALL_RESET;
      phase_q       <= '0;
      idle_ticks_q  <= '0;
      last_stamp_q  <= '0;
      period_q      <= '0;
      backward_q    <= 1'b0;
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          etp_pkg::CFG_RATE_NUM: rate_num_q    <= cfg_data_i;
          etp_pkg::CFG_STALL:    stall_ticks_q <= cfg_data_i[etp_pkg::STALL_W-1:0];
          default: begin
          end
        endcase
      end
      phase_q      <= phase_d;
      idle_ticks_q <= idle_ticks_d;
      last_stamp_q <= last_stamp_d;
      period_q     <= period_d;
      backward_q   <= backward_d;
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    speed_q    <= speed_d;
    out_back_q <= out_back_d;
  end

  assign out_valid_o       = out_valid_q;
  assign speed_q8_o        = speed_q;
  assign moving_backward_o = out_back_q;

  // input must be held off while the divider runs
  `ETP_ASSERT_IMPL(a_div_blocks_in, div_stat.busy, !in_ready_o, "input ready during divide")
  // a divide result only lands while the sequencer waits for it
  `ETP_ASSERT_IMPL(a_done_in_div, div_stat.done, state_q == ST_DIV, "stray divider done")
  // forward words never carry a negative speed
  `ETP_ASSERT_IMPL(a_fwd_sign, out_valid_o && !moving_backward_o, !speed_q8_o[etp_pkg::SPEED_W-1],
                   "negative speed while forward")
  // stall counter saturates rather than wrapping
  `ETP_ASSERT_NEXT(a_idle_sat, idle_ticks_q == etp_pkg::IDLE_MAX && in_acc && kind_i,
                   idle_ticks_q == etp_pkg::IDLE_MAX, "stall count wrapped")

endmodule

>>> rtl/etp_div.sv
// ----------------------------------------------------------------------------
// etp_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module etp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [etp_pkg::NUM_W-1:0]   dividend_i,
  input  logic [etp_pkg::STAMP_W-1:0] divisor_i,
  output etp_pkg::div_stat_t          stat_o,
  output logic [etp_pkg::NUM_W-1:0]   quotient_o
);

  // dividend shifts out of the top while quotient bits shift in at the bottom
  logic [etp_pkg::NUM_W-1:0]     num_q, num_d;
  logic [etp_pkg::STAMP_W-1:0]   den_q, den_d;
  logic [etp_pkg::STAMP_W-1:0]   rem_q, rem_d;
  logic [etp_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;

  logic [etp_pkg::STAMP_W:0]     rem_sh;
  logic [etp_pkg::STAMP_W:0]     rem_sub;
  logic                          ge;

  assign rem_sh  = {rem_q, num_q[etp_pkg::NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = etp_pkg::DIV_CNT_W'(etp_pkg::NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[etp_pkg::NUM_W-2:0], ge};
      rem_d = ge ? rem_sub[etp_pkg::STAMP_W-1:0] : rem_sh[etp_pkg::STAMP_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == etp_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = num_q;

endmodule
